// ===== rtl/core/lpmr_pkg.sv =====
// Package for the length-prefixed message ring: word structs, operation and
// status codes, and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package lpmr_pkg;

    localparam int LEN_W    = 10;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 11;
    localparam int OP_W     = 3;

    localparam logic [OP_W-1:0] OP_BEGIN_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_BYTE  = 3'd1;
    localparam logic [OP_W-1:0] OP_BEGIN_READ  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_BYTE   = 3'd3;
    localparam logic [OP_W-1:0] OP_SKIP        = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MSG   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ORDER    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [LEN_W-1:0]  message_length;
        logic [DATA_W-1:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    length_out;
        logic [DATA_W-1:0]   data_out;
        logic                last_byte;
        logic                is_empty;
        logic                is_full;
        logic [FREE_W-1:0]   free_bytes;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HDR_WR,
        ST_HDR_RD
    } state_t;

endpackage

// ===== rtl/core/lpmr_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lpmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/length_prefixed_message_ring.sv =====
// Length-prefixed message ring: top level with controller and ring pointers.
// Depends on lpmr_pkg and lpmr_ram.
//
//   channel   ports                        word
//   input     s_valid, s_ready, s_word     operation, message_length, data_byte
//   result    m_valid, m_ready, m_word     status, lengths, data, flags, free bytes
//
// Each item is taken in the idle state and executed in the cycle after. Begin
// write, begin read and a skip of a new message go on through the header
// states: the single RAM port moves one header byte a cycle, but the last
// header byte waits while the output register is busy.
// The byte RAM needs no clearing after reset; only written bytes are ever read.
// A finished word waits in the output register; the last step of the next item
// stalls until that register is free.
`timescale 1ns / 1ps

module length_prefixed_message_ring #(
    parameter int CAPACITY     = 1024,
    parameter int HEADER_BYTES = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lpmr_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output lpmr_pkg::out_word_t m_word
);

    import lpmr_pkg::*;

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
    localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int SRC_W  = (8 * HEADER_BYTES > LEN_W) ? 8 * HEADER_BYTES : LEN_W;

    state_t state_reg, state_next;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] pub_end_reg, pub_end_next;
    logic             full_reg, full_next;
    logic [LEN_W-1:0] wr_rem_reg, wr_rem_next;
    logic [LEN_W-1:0] rd_rem_reg, rd_rem_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_word_reg, m_word_next;
    in_word_t         item_reg, item_next;
    logic [HCNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0] len_acc_reg, len_acc_next;

    logic              mem_we;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    logic              finishing;
    logic              advance;
    logic              go_hdr_wr;
    logic              go_hdr_rd;
    logic              out_free;
    logic [HCNT_W-1:0] hdr_idx;
    logic              hdr_last;
    logic [LEN_W-1:0]  hdr_len;
    logic [DATA_W-1:0] hdr_wr_byte;
    logic [CNT_W-1:0]  used_now;
    logic              no_msg_now;
    logic              len_bad;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [LEN_W-1:0] n);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(n);
        if (s >= SUM_W'(CAPACITY)) begin
            s = s - SUM_W'(CAPACITY);
        end
        wrap_add = PTR_W'(s);
    endfunction

    // Distance from b forward to a around the ring.
    function automatic logic [CNT_W-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                                   input logic [PTR_W-1:0] b);
        if (a >= b) begin
            ring_dist = CNT_W'(a) - CNT_W'(b);
        end else begin
            ring_dist = CNT_W'(a) + CNT_W'(CAPACITY) - CNT_W'(b);
        end
    endfunction

    function automatic logic [CNT_W-1:0] used_count(input logic [PTR_W-1:0] wp,
                                                    input logic [PTR_W-1:0] rp,
                                                    input logic full);
        used_count = full ? CNT_W'(CAPACITY) : ring_dist(wp, rp);
    endfunction

    // True when no published message is left beyond the one being read.
    function automatic logic no_message(input logic [PTR_W-1:0] pe,
                                        input logic [PTR_W-1:0] rp,
                                        input logic full,
                                        input logic [LEN_W-1:0] wr,
                                        input logic [LEN_W-1:0] rr);
        logic [CNT_W-1:0] pub;
        pub = ring_dist(pe, rp);
        if (pub == '0 && full && wr == '0) begin
            pub = CNT_W'(CAPACITY);
        end
        no_message = SUM_W'(pub) <= SUM_W'(rr);
    endfunction

    lpmr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wr_ptr_reg),
        .wdata (mem_wdata),
        .raddr (rd_ptr_next),
        .rdata (mem_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;
    assign out_free = !m_valid_reg || m_ready;

    // The RAM reads at the next read pointer every cycle, so its data always
    // holds the byte at the current read pointer when a read step needs it.
    assign hdr_idx     = (state_reg == ST_EXEC) ? '0 : hdr_cnt_reg;
    assign hdr_last    = (hdr_idx == HCNT_W'(HEADER_BYTES - 1));
    assign hdr_len     = ((state_reg == ST_EXEC) ? '0 : len_acc_reg)
                       | (LEN_W'(mem_rdata) << {hdr_idx, 3'b000});
    assign hdr_wr_byte = DATA_W'(SRC_W'(item_reg.message_length) >> {hdr_idx, 3'b000});

    assign used_now   = used_count(wr_ptr_reg, rd_ptr_reg, full_reg);
    assign no_msg_now = no_message(pub_end_reg, rd_ptr_reg, full_reg, wr_rem_reg,
                                   rd_rem_reg);
    assign len_bad = (item_reg.message_length == '0)
                   || ((8 * HEADER_BYTES < LEN_W)
                       && ((item_reg.message_length >> (8 * HEADER_BYTES)) != '0))
                   || (SUM_W'(item_reg.message_length) + SUM_W'(HEADER_BYTES)
                       > SUM_W'(CAPACITY) - SUM_W'(used_now));

    // Datapath and result word.
    always_comb begin
        logic do_hdr_wr;
        logic do_hdr_rd;
        logic do_put;
        logic [PTR_W-1:0] wp_inc;
        logic [PTR_W-1:0] rp_inc;

        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        pub_end_next = pub_end_reg;
        full_next    = full_reg;
        wr_rem_next  = wr_rem_reg;
        rd_rem_next  = rd_rem_reg;
        item_next    = item_reg;
        hdr_cnt_next = hdr_cnt_reg;
        len_acc_next = len_acc_reg;
        mem_we       = 1'b0;
        mem_wdata    = item_reg.data_byte;
        finishing    = 1'b0;
        go_hdr_wr    = 1'b0;
        go_hdr_rd    = 1'b0;
        do_hdr_wr    = 1'b0;
        do_hdr_rd    = 1'b0;
        do_put       = 1'b0;
        wp_inc       = wrap_inc(wr_ptr_reg);
        rp_inc       = wrap_inc(rd_ptr_reg);

        m_word_next            = m_word_reg;
        m_word_next.status     = STATUS_OK;
        m_word_next.length_out = '0;
        m_word_next.data_out   = '0;
        m_word_next.last_byte  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_word;
                end
            end
            ST_EXEC: begin
                finishing = 1'b1;
                case (item_reg.operation)
                    OP_BEGIN_WRITE: begin
                        if (wr_rem_reg != '0) begin
                            m_word_next.status = STATUS_ORDER;
                        end else if (len_bad) begin
                            m_word_next.status = STATUS_NO_SPACE;
                        end else begin
                            do_hdr_wr = 1'b1;
                        end
                    end
                    OP_WRITE_BYTE: begin
                        if (wr_rem_reg == '0) begin
                            m_word_next.status = STATUS_ORDER;
                        end else begin
                            do_put      = 1'b1;
                            wr_rem_next = wr_rem_reg - 1'b1;
                            if (wr_rem_next == '0) begin
                                pub_end_next = wp_inc;
                            end
                        end
                    end
                    OP_BEGIN_READ: begin
                        if (rd_rem_reg != '0) begin
                            m_word_next.status = STATUS_ORDER;
                        end else if (no_msg_now) begin
                            m_word_next.status = STATUS_NO_MSG;
                        end else begin
                            do_hdr_rd = 1'b1;
                        end
                    end
                    OP_READ_BYTE: begin
                        if (rd_rem_reg == '0) begin
                            m_word_next.status = STATUS_ORDER;
                        end else begin
                            m_word_next.data_out  = mem_rdata;
                            rd_ptr_next           = rp_inc;
                            full_next             = 1'b0;
                            rd_rem_next           = rd_rem_reg - 1'b1;
                            m_word_next.last_byte = (rd_rem_next == '0);
                        end
                    end
                    OP_SKIP: begin
                        if (rd_rem_reg != '0) begin
                            m_word_next.length_out = rd_rem_reg;
                            rd_ptr_next            = wrap_add(rd_ptr_reg, rd_rem_reg);
                            full_next              = 1'b0;
                            rd_rem_next            = '0;
                        end else if (no_msg_now) begin
                            m_word_next.status = STATUS_NO_MSG;
                        end else begin
                            do_hdr_rd = 1'b1;
                        end
                    end
                    default: begin
                        m_word_next.status = STATUS_ORDER;
                    end
                endcase
            end
            ST_HDR_WR: begin
                do_hdr_wr = 1'b1;
            end
            ST_HDR_RD: begin
                do_hdr_rd = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_hdr_wr) begin
            do_put       = 1'b1;
            mem_wdata    = hdr_wr_byte;
            hdr_cnt_next = hdr_idx + 1'b1;
            finishing    = hdr_last;
            go_hdr_wr    = !hdr_last;
            if (hdr_last) begin
                wr_rem_next = item_reg.message_length;
            end
        end

        if (do_put) begin
            mem_we      = 1'b1;
            wr_ptr_next = wp_inc;
            if (wp_inc == rd_ptr_reg) begin
                full_next = 1'b1;
            end
        end

        if (do_hdr_rd) begin
            rd_ptr_next  = rp_inc;
            full_next    = 1'b0;
            len_acc_next = hdr_len;
            hdr_cnt_next = hdr_idx + 1'b1;
            finishing    = hdr_last;
            go_hdr_rd    = !hdr_last;
            if (hdr_last) begin
                m_word_next.length_out = hdr_len;
                if (item_reg.operation == OP_BEGIN_READ) begin
                    rd_rem_next = hdr_len;
                end else if (hdr_len != '0) begin
                    rd_ptr_next = wrap_add(rp_inc, hdr_len);
                end
            end
        end

        m_word_next.is_empty   = no_message(pub_end_next, rd_ptr_next, full_next,
                                            wr_rem_next, rd_rem_next);
        m_word_next.is_full    = full_next;
        m_word_next.free_bytes = FREE_W'(CNT_W'(CAPACITY)
                                 - used_count(wr_ptr_next, rd_ptr_next, full_next));

        // The last step of an item waits until the output register is free.
        advance = !finishing || out_free;
        if (!advance) begin
            rd_ptr_next  = rd_ptr_reg;
            wr_ptr_next  = wr_ptr_reg;
            pub_end_next = pub_end_reg;
            full_next    = full_reg;
            wr_rem_next  = wr_rem_reg;
            rd_rem_next  = rd_rem_reg;
            hdr_cnt_next = hdr_cnt_reg;
            len_acc_next = len_acc_reg;
            mem_we       = 1'b0;
        end

        if (finishing && advance) begin
            m_valid_next = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_word_next  = m_word_reg;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (go_hdr_wr) begin
                    state_next = ST_HDR_WR;
                end else if (go_hdr_rd) begin
                    state_next = ST_HDR_RD;
                end else if (advance) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HDR_WR, ST_HDR_RD: begin
                if (finishing && advance) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            pub_end_reg <= '0;
            full_reg    <= 1'b0;
            wr_rem_reg  <= '0;
            rd_rem_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            pub_end_reg <= pub_end_next;
            full_reg    <= full_next;
            wr_rem_reg  <= wr_rem_next;
            rd_rem_reg  <= rd_rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        hdr_cnt_reg <= hdr_cnt_next;
        len_acc_reg <= len_acc_next;
        m_word_reg  <= m_word_next;
    end

endmodule

// ===== sim/length_prefixed_message_ring_tb.sv =====
// Self-checking testbench for length_prefixed_message_ring: directed words, then
// random message traffic, checked against an in-bench model of the byte ring.
// Depends on lpmr_pkg and the ring RTL.
`timescale 1ns / 1ps

module length_prefixed_message_ring_tb;
    import lpmr_pkg::*;

    localparam int RING_SIZE   = 1024;
    localparam int HDR_BYTES   = 2;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_LONG   = 400;
    localparam int MAX_REPORTS = 10;

    localparam logic [OP_W-1:0]  OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0]  OP_UNUSED_HI = 3'd7;
    localparam logic [LEN_W-1:0] LEN_ALL_ONES = '1;

    typedef struct packed {
        in_word_t  item;
        logic      typed;
        out_word_t want;
    } step_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    // Model of the ring, advanced once per accepted input word.
    logic [7:0]  ring_bytes [RING_SIZE];
    int unsigned rd_ptr, wr_ptr, pub_end, wr_left, rd_left;
    bit          ring_full;

    out_word_t replies_due [$];
    int        fail_count, items_sent, results_checked, full_results;
    int        quiet_cycles;
    int        hold_cycles, rx_left;
    bit        rx_level, rx_idling, tx_idling;

    length_prefixed_message_ring #(
        .CAPACITY     (RING_SIZE),
        .HEADER_BYTES (HDR_BYTES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned ring_used();
        return ring_full ? RING_SIZE : (wr_ptr + RING_SIZE - rd_ptr) % RING_SIZE;
    endfunction

    function automatic int unsigned ring_free();
        return RING_SIZE - ring_used();
    endfunction

    // A message still being written is not published, and an open read has
    // already claimed the bytes of the message it is reading.
    function automatic bit nothing_to_read();
        int unsigned published;
        published = (pub_end + RING_SIZE - rd_ptr) % RING_SIZE;
        if (published == 0 && ring_full && wr_left == 0) begin
            published = RING_SIZE;
        end
        return published <= rd_left;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        ring_bytes[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % RING_SIZE;
        if (wr_ptr == rd_ptr) begin
            ring_full = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pop_byte();
        logic [7:0] b;
        b = ring_bytes[rd_ptr];
        rd_ptr = (rd_ptr + 1) % RING_SIZE;
        ring_full = 1'b0;
        return b;
    endfunction

    function automatic int unsigned pop_header();
        int unsigned len;
        len = 0;
        for (int i = 0; i < HDR_BYTES; i++) begin
            len |= int'(pop_byte()) << (8 * i);
        end
        return len & 32'h3FF;
    endfunction

    function automatic out_word_t ring_reply(in_word_t w);
        out_word_t   r;
        int unsigned n;
        r = '0;
        r.status = STATUS_OK;
        case (w.operation)
            OP_BEGIN_WRITE: begin
                if (wr_left != 0) begin
                    r.status = STATUS_ORDER;
                end else if (w.message_length == 0
                             || (int'(w.message_length) >> (8 * HDR_BYTES)) != 0
                             || int'(w.message_length) + HDR_BYTES > ring_free()) begin
                    r.status = STATUS_NO_SPACE;
                end else begin
                    for (int i = 0; i < HDR_BYTES; i++) begin
                        push_byte(8'(w.message_length >> (8 * i)));
                    end
                    wr_left = w.message_length;
                end
            end
            OP_WRITE_BYTE: begin
                if (wr_left == 0) begin
                    r.status = STATUS_ORDER;
                end else begin
                    push_byte(w.data_byte);
                    wr_left--;
                    if (wr_left == 0) begin
                        pub_end = wr_ptr;
                    end
                end
            end
            OP_BEGIN_READ: begin
                if (rd_left != 0) begin
                    r.status = STATUS_ORDER;
                end else if (nothing_to_read()) begin
                    r.status = STATUS_NO_MSG;
                end else begin
                    rd_left = pop_header();
                    r.length_out = LEN_W'(rd_left);
                end
            end
            OP_READ_BYTE: begin
                if (rd_left == 0) begin
                    r.status = STATUS_ORDER;
                end else begin
                    r.data_out = pop_byte();
                    rd_left--;
                    r.last_byte = (rd_left == 0);
                end
            end
            OP_SKIP: begin
                if (rd_left != 0) begin
                    r.length_out = LEN_W'(rd_left);
                    rd_ptr = (rd_ptr + rd_left) % RING_SIZE;
                    ring_full = 1'b0;
                    rd_left = 0;
                end else if (nothing_to_read()) begin
                    r.status = STATUS_NO_MSG;
                end else begin
                    n = pop_header();
                    if (n != 0) begin
                        rd_ptr = (rd_ptr + n) % RING_SIZE;
                        ring_full = 1'b0;
                    end
                    r.length_out = LEN_W'(n);
                end
            end
            default: begin
                r.status = STATUS_ORDER;
            end
        endcase
        r.is_empty   = nothing_to_read();
        r.is_full    = ring_full;
        r.free_bytes = FREE_W'(ring_free());
        return r;
    endfunction

    function automatic in_word_t mk_word(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                         logic [DATA_W-1:0] data);
        return '{operation: op, message_length: len, data_byte: data};
    endfunction

    // Rows right after reset carry their answer: nothing stored, all space free.
    function automatic step_t plan_row(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                       logic [DATA_W-1:0] data, bit typed,
                                       logic [STATUS_W-1:0] st);
        step_t s;
        s.item  = mk_word(op, len, data);
        s.typed = typed;
        s.want  = '{status: st, length_out: '0, data_out: '0, last_byte: 1'b0,
                    is_empty: 1'b1, is_full: 1'b0, free_bytes: FREE_W'(RING_SIZE)};
        return s;
    endfunction

    function automatic string show(out_word_t r);
        return $sformatf("status %0d len %0d data %02h last %0b empty %0b full %0b free %0d",
                         r.status, r.length_out, r.data_out, r.last_byte, r.is_empty,
                         r.is_full, r.free_bytes);
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 8);
        end else if (r < 95) begin
            return $urandom_range(9, 60);
        end
        return $urandom_range(61, 150);
    endfunction

    task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                             input out_word_t want = '0);
        int        gap;
        out_word_t predicted;
        gap = (tx_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = ring_reply(w);
        replies_due.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic sender_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_replies();
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    task automatic read_side_op();
        case ($urandom_range(0, 2))
            0: send_word(mk_word(OP_BEGIN_READ, LEN_W'($urandom), DATA_W'($urandom)));
            1: send_word(mk_word(OP_READ_BYTE, LEN_W'($urandom), DATA_W'($urandom)));
            default: send_word(mk_word(OP_SKIP, LEN_W'($urandom), DATA_W'($urandom)));
        endcase
    endtask

    // A refused begin leaves no write open; a write left open by earlier noise
    // is finished here as well.
    task automatic write_message(int unsigned len, bit mix_reads);
        send_word(mk_word(OP_BEGIN_WRITE, LEN_W'(len), DATA_W'($urandom)));
        while (wr_left != 0) begin
            if (mix_reads && $urandom_range(0, 9) == 0) begin
                read_side_op();
            end
            send_word(mk_word(OP_WRITE_BYTE, LEN_W'($urandom), DATA_W'($urandom)));
        end
    endtask

    task automatic read_message();
        int unsigned keep;
        send_word(mk_word(OP_BEGIN_READ, LEN_W'($urandom), DATA_W'($urandom)));
        keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, rd_left) : 0;
        while (rd_left > keep) begin
            send_word(mk_word(OP_READ_BYTE, LEN_W'($urandom), DATA_W'($urandom)));
        end
        if (rd_left != 0) begin
            send_word(mk_word(OP_SKIP, LEN_W'($urandom), DATA_W'($urandom)));
        end
    endtask

    // Begin-write noise always sits just outside what can be accepted.
    task automatic send_noise();
        logic [LEN_W-1:0] len;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: len = '0;
                1: len = LEN_ALL_ONES;
                default: len = (ring_free() > 1) ? LEN_W'(ring_free() - 1) : '0;
            endcase
            send_word(mk_word(OP_BEGIN_WRITE, len, DATA_W'($urandom)));
        end else begin
            send_word(mk_word(OP_W'($urandom_range(OP_WRITE_BYTE, OP_UNUSED_HI)),
                              LEN_W'($urandom), DATA_W'($urandom)));
        end
    endtask

    task automatic run_mixed(int unsigned count);
        int unsigned target, r;
        target = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                write_message(pick_length(), 1'b1);
            end else if (r < 70) begin
                read_message();
            end else if (r < 82) begin
                send_word(mk_word(OP_SKIP, LEN_W'($urandom), DATA_W'($urandom)));
            end else begin
                send_noise();
            end
        end
    endtask

    // Fill the ring to the last byte: each message either takes all that is left
    // or leaves room for at least one more.
    task automatic fill_ring();
        int unsigned space;
        space = ring_free();
        while (space >= HDR_BYTES + 1) begin
            if (space - HDR_BYTES <= 120) begin
                write_message(space - HDR_BYTES, 1'b0);
            end else begin
                write_message($urandom_range(1, (space - HDR_BYTES - 3 < 120) ?
                                                space - HDR_BYTES - 3 : 120), 1'b0);
            end
            space = ring_free();
        end
    endtask

    task automatic drain_ring();
        while (!nothing_to_read() || rd_left != 0) begin
            if ($urandom_range(0, 3) == 0) begin
                read_message();
            end else begin
                send_word(mk_word(OP_SKIP, LEN_W'($urandom), DATA_W'($urandom)));
            end
        end
    endtask

    // Receiver: random ready bursts, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        rx_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_left == 0) begin
                if (hold_cycles != 0) begin
                    rx_level    = 1'b0;
                    rx_left     = hold_cycles;
                    hold_cycles = 0;
                end else if (rx_idling && $urandom_range(0, 3) == 0) begin
                    rx_level = 1'b0;
                    rx_left  = $urandom_range(1, 6);
                end else begin
                    rx_level = 1'b1;
                    rx_left  = $urandom_range(1, 12);
                end
            end
            m_ready <= rx_level;
            rx_left--;
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("result with nothing expected: %s", show(m_word));
                end
            end else begin
                want = replies_due.pop_front();
                results_checked++;
                if (m_word.is_full) begin
                    full_results++;
                end
                if (m_word !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch on result %0d", results_checked);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(m_word));
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no word moved for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        step_t plan [$];
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_word       = '0;
        quiet_cycles = 0;
        hold_cycles  = 0;
        tx_idling    = 1'b1;
        rx_idling    = 1'b1;
        rd_ptr       = 0;
        wr_ptr       = 0;
        pub_end      = 0;
        wr_left      = 0;
        rd_left      = 0;
        ring_full    = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        plan = '{
            plan_row(OP_SKIP,        '0,           8'h00, 1'b1, STATUS_NO_MSG),
            plan_row(OP_BEGIN_READ,  LEN_ALL_ONES, 8'hFF, 1'b1, STATUS_NO_MSG),
            plan_row(OP_READ_BYTE,   '0,           8'h00, 1'b1, STATUS_ORDER),
            plan_row(OP_WRITE_BYTE,  '0,           8'hFF, 1'b1, STATUS_ORDER),
            plan_row(OP_UNUSED_LO,   LEN_ALL_ONES, 8'hFF, 1'b1, STATUS_ORDER),
            plan_row(OP_UNUSED_HI,   '0,           8'h00, 1'b1, STATUS_ORDER),
            plan_row(OP_BEGIN_WRITE, '0,           8'h00, 1'b1, STATUS_NO_SPACE),
            plan_row(OP_BEGIN_WRITE, LEN_ALL_ONES, 8'h00, 1'b1, STATUS_NO_SPACE),
            plan_row(OP_BEGIN_WRITE, 10'd3,        8'h00, 1'b0, STATUS_OK),
            plan_row(OP_BEGIN_WRITE, 10'd2,        8'h00, 1'b0, STATUS_OK),
            plan_row(OP_WRITE_BYTE,  '0,           8'h00, 1'b0, STATUS_OK),
            plan_row(OP_WRITE_BYTE,  '0,           8'hFF, 1'b0, STATUS_OK),
            plan_row(OP_BEGIN_READ,  '0,           8'h00, 1'b0, STATUS_OK),
            plan_row(OP_WRITE_BYTE,  '0,           8'hA5, 1'b0, STATUS_OK),
            plan_row(OP_WRITE_BYTE,  '0,           8'h11, 1'b0, STATUS_OK),
            plan_row(OP_BEGIN_WRITE, 10'd1022,     8'h00, 1'b0, STATUS_OK),
            plan_row(OP_BEGIN_WRITE, 10'd1,        8'h00, 1'b0, STATUS_OK),
            plan_row(OP_WRITE_BYTE,  '0,           8'h5A, 1'b0, STATUS_OK),
            plan_row(OP_BEGIN_READ,  '0,           8'h00, 1'b0, STATUS_OK),
            plan_row(OP_BEGIN_READ,  '0,           8'h00, 1'b0, STATUS_OK),
            plan_row(OP_READ_BYTE,   '0,           8'h00, 1'b0, STATUS_OK),
            plan_row(OP_SKIP,        '0,           8'h00, 1'b0, STATUS_OK),
            plan_row(OP_READ_BYTE,   '0,           8'h00, 1'b0, STATUS_OK),
            plan_row(OP_SKIP,        '0,           8'h00, 1'b0, STATUS_OK),
            plan_row(OP_SKIP,        '0,           8'h00, 1'b0, STATUS_OK)
        };
        foreach (plan[i]) begin
            send_word(plan[i].item, plan[i].typed, plan[i].want);
        end

        run_mixed(80);

        // The receiver holds off ready as the ring filling begins, so the block backs up.
        hold_cycles = HOLD_LONG;
        fill_ring();
        send_word(mk_word(OP_BEGIN_WRITE, 10'd1, 8'h00));
        send_word(mk_word(OP_WRITE_BYTE, '0, 8'h00));
        sender_idle();
        wait_replies();
        drain_ring();

        run_mixed(50);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_mixed(40);

        sender_idle();
        wait_replies();
        repeat (20) @(posedge aclk);
        if (replies_due.size() != 0) begin
            fail_count++;
        end

        $display("Sent %0d words of every operation and checked %0d results;",
                 items_sent, results_checked);
        $display("the ring was filled to its last byte, with %0d results showing it full.",
                 full_results);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== length_prefixed_message_ring.f =====
rtl/core/lpmr_pkg.sv
rtl/core/lpmr_ram.sv
rtl/core/length_prefixed_message_ring.sv
sim/length_prefixed_message_ring_tb.sv
